/* rtl/deq_pkg.sv */
`default_nettype none
package deq_pkg;

	// Store geometry
	localparam int unsigned DEPTH = 64;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W = IDX_W + 2;

	// Field widths
	localparam int unsigned WORD_W = 32;
	localparam int unsigned REQ_W = 2;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned RES_W = WORD_W + STAT_W + CNT_W + 1;
	localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;

	// Request kinds
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	localparam logic [WORD_W-1:0] MOST_NEG = 32'h8000_0000;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic load;
	} deq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_valid;
	} deq_stat_t;

	// Circular wrap of a position below twice the depth
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] pos);
		logic [SUM_W-1:0] red;
		red = (pos >= SUM_W'(DEPTH)) ? pos - SUM_W'(DEPTH) : pos;
		return red[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/deq_ram.sv */
`default_nettype none
module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/deq_ctrl.sv */
`default_nettype none
module deq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output      logic               s_tready,
	input  wire logic               m_tready,
	input  wire deq_pkg::deq_stat_t stat,
	output      deq_pkg::deq_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic state_q;
	logic state_nxt;

	// Take a request when idle; unload the read result once the output slot frees
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && s_tvalid;
		cmd.load = (state_q == ST_BUSY) && (!stat.out_valid || m_tready);
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					state_nxt = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (cmd.load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// An accepted request always moves to the result phase
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_BUSY))
		else $error("accepted request did not enter busy");

	// A result waits while the output slot is occupied and not taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY && stat.out_valid && !m_tready) |=> (state_q == ST_BUSY))
		else $error("result dropped while output stalled");

	// No request is taken during the result phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY) |-> !cmd.accept)
		else $error("request accepted while busy");

endmodule
`default_nettype wire

/* rtl/deq_dp.sv */
`default_nettype none
module deq_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire deq_pkg::deq_cmd_t             cmd,
	output      deq_pkg::deq_stat_t            stat,
	input  wire logic [deq_pkg::REQ_W-1:0]     req_type,
	input  wire logic [deq_pkg::WORD_W-1:0]    push_value,
	input  wire logic                          m_tready,
	output      logic                          out_valid,
	output      logic [deq_pkg::WORD_W-1:0]    pop_value,
	output      logic [deq_pkg::STAT_W-1:0]    status,
	output      logic [deq_pkg::CNT_W-1:0]     entry_count,
	output      logic                          is_empty
);

	logic [deq_pkg::IDX_W-1:0]  head_q, head_nxt;
	logic [deq_pkg::CNT_W-1:0]  count_q, count_nxt;
	logic [deq_pkg::SUM_W-1:0]  tail_sum, last_sum;
	logic [deq_pkg::IDX_W-1:0]  head_dec, head_inc;
	logic                       full, none;
	logic                       wr_en, rd_en;
	logic [deq_pkg::IDX_W-1:0]  wr_addr, rd_addr;
	logic [deq_pkg::WORD_W-1:0] rd_data;
	logic [deq_pkg::STAT_W-1:0] req_status;
	logic                       req_pop;

	logic [deq_pkg::STAT_W-1:0] pend_status_q;
	logic [deq_pkg::CNT_W-1:0]  pend_count_q;
	logic                       pend_pop_q;

	logic                       out_valid_q;
	logic [deq_pkg::WORD_W-1:0] out_value_q;
	logic [deq_pkg::STAT_W-1:0] out_status_q;
	logic [deq_pkg::CNT_W-1:0]  out_count_q;

	// Pointer arithmetic
	always_comb begin
		tail_sum = deq_pkg::SUM_W'(head_q) + deq_pkg::SUM_W'(count_q);
		last_sum = tail_sum - deq_pkg::SUM_W'(1);
		head_dec = (head_q == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)
			: head_q - deq_pkg::IDX_W'(1);
		head_inc = deq_pkg::wrap_idx(deq_pkg::SUM_W'(head_q) + deq_pkg::SUM_W'(1));
		full = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
		none = (count_q == '0);
	end

	// Request decode
	always_comb begin
		wr_en = 1'b0;
		rd_en = 1'b0;
		wr_addr = head_dec;
		rd_addr = head_q;
		head_nxt = head_q;
		count_nxt = count_q;
		req_status = deq_pkg::STAT_DONE;
		req_pop = 1'b0;
		unique case (req_type)
			deq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					req_status = deq_pkg::STAT_FULL;
				end else begin
					wr_en = 1'b1;
					wr_addr = head_dec;
					head_nxt = head_dec;
					count_nxt = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					req_status = deq_pkg::STAT_FULL;
				end else begin
					wr_en = 1'b1;
					wr_addr = deq_pkg::wrap_idx(tail_sum);
					count_nxt = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::REQ_POP_FRONT: begin
				if (none) begin
					req_status = deq_pkg::STAT_EMPTY;
				end else begin
					rd_en = 1'b1;
					req_pop = 1'b1;
					rd_addr = head_q;
					head_nxt = head_inc;
					count_nxt = count_q - deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::REQ_POP_BACK: begin
				if (none) begin
					req_status = deq_pkg::STAT_EMPTY;
				end else begin
					rd_en = 1'b1;
					req_pop = 1'b1;
					rd_addr = deq_pkg::wrap_idx(last_sum);
					count_nxt = count_q - deq_pkg::CNT_W'(1);
				end
			end
			default: req_status = deq_pkg::STAT_DONE;
		endcase
	end

	deq_ram #(
		.WIDTH(deq_pkg::WORD_W),
		.DEPTH(deq_pkg::DEPTH)
	) u_store (
		.clk(clk),
		.wr_en(wr_en && cmd.accept),
		.wr_addr(wr_addr),
		.wr_data(push_value),
		.rd_en(rd_en && cmd.accept),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Front index and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			head_q <= head_nxt;
			count_q <= count_nxt;
		end
	end

	// Request outcome held until the read data arrives
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_status_q <= req_status;
			pend_count_q <= count_nxt;
			pend_pop_q <= req_pop;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_value_q <= pend_pop_q ? rd_data : deq_pkg::MOST_NEG;
			out_status_q <= pend_status_q;
			out_count_q <= pend_count_q;
		end
	end

	assign stat.out_valid = out_valid_q;
	assign out_valid = out_valid_q;
	assign pop_value = out_value_q;
	assign status = out_status_q;
	assign entry_count = out_count_q;
	assign is_empty = (out_count_q == '0);

	// Count never exceeds the store depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
		else $error("count beyond depth");

	// A load never overwrites a result that is not taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || m_tready))
		else $error("output result overwritten");

	// A refused push leaves the queue full
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == deq_pkg::STAT_FULL)
			|-> (out_count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH)))
		else $error("full status with room left");

	// A refused pop reports an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == deq_pkg::STAT_EMPTY) |-> is_empty)
		else $error("empty status on nonempty queue");

endmodule
`default_nettype wire

/* rtl/double_ended_queue.sv */
// Channel   Dir  tdata (low bit up)                                  tuser
// s_*       in   push_value[31:0]                                    req_type[1:0]
// m_*       out  pop_value[31:0] status[33:32] entry_count[40:34]    -
//                is_empty[41], zero fill to 48 bits
//
// Each request is accepted, then the registered read of the word store returns
// the popped word into the output register. No new request is taken until the
// previous result has been loaded into the output register.
// Reset clears the front index, the count and the output valid; store contents
// are undefined until pushed. A stalled result holds in the output register while
// the next request is accepted; that request then waits before it is unloaded.
`default_nettype none
module double_ended_queue (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	// push_value[31:0]
	input  wire logic [deq_pkg::WORD_W-1:0]      s_tdata,
	// req_type[1:0]
	input  wire logic [deq_pkg::REQ_W-1:0]       s_tuser,
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	// pop_value[31:0], status[33:32], entry_count[40:34], is_empty[41], zeros
	output      logic [deq_pkg::M_TDATA_W-1:0]   m_tdata
);

	deq_pkg::deq_cmd_t          cmd;
	deq_pkg::deq_stat_t         stat;
	logic [deq_pkg::WORD_W-1:0] pop_value;
	logic [deq_pkg::STAT_W-1:0] status;
	logic [deq_pkg::CNT_W-1:0]  entry_count;
	logic                       is_empty;

	deq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tready(m_tready),
		.stat(stat),
		.cmd(cmd)
	);

	deq_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.req_type(s_tuser),
		.push_value(s_tdata),
		.m_tready(m_tready),
		.out_valid(m_tvalid),
		.pop_value(pop_value),
		.status(status),
		.entry_count(entry_count),
		.is_empty(is_empty)
	);

	// Result packing
	assign m_tdata = deq_pkg::M_TDATA_W'({is_empty, entry_count, status, pop_value});

endmodule
`default_nettype wire

/* bench/double_ended_queue_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_tb;

	// Package constants used here
	localparam int unsigned DEPTH = deq_pkg::DEPTH;
	localparam int unsigned IDX_W = deq_pkg::IDX_W;
	localparam int unsigned CNT_W = deq_pkg::CNT_W;
	localparam int unsigned WORD_W = deq_pkg::WORD_W;
	localparam int unsigned REQ_W = deq_pkg::REQ_W;
	localparam int unsigned STAT_W = deq_pkg::STAT_W;
	localparam int unsigned M_TDATA_W = deq_pkg::M_TDATA_W;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = deq_pkg::REQ_PUSH_FRONT;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK = deq_pkg::REQ_PUSH_BACK;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT = deq_pkg::REQ_POP_FRONT;
	localparam logic [REQ_W-1:0] REQ_POP_BACK = deq_pkg::REQ_POP_BACK;
	localparam logic [STAT_W-1:0] STAT_DONE = deq_pkg::STAT_DONE;
	localparam logic [STAT_W-1:0] STAT_EMPTY = deq_pkg::STAT_EMPTY;
	localparam logic [STAT_W-1:0] STAT_FULL = deq_pkg::STAT_FULL;
	localparam logic [WORD_W-1:0] MOST_NEG = deq_pkg::MOST_NEG;

	// Result field offsets within m_tdata
	localparam int unsigned ST_LSB = WORD_W;
	localparam int unsigned CNT_LSB = WORD_W + STAT_W;
	localparam int unsigned EMP_BIT = WORD_W + STAT_W + CNT_W;
	localparam int unsigned RANDOM_REQS = 600;

	typedef struct {
		logic [WORD_W-1:0] pop_value;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  entry_count;
		logic              is_empty;
	} deq_result_t;

	// One row of the directed table; reps repeats the row, rnd draws a fresh word
	typedef struct {
		logic [REQ_W-1:0]  kind;
		logic [WORD_W-1:0] value;
		int                reps;
		bit                rnd;
		bit                typed;
		deq_result_t       want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [WORD_W-1:0]    s_tdata;
	logic [REQ_W-1:0]     s_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Shadow copy of the queue
	logic [WORD_W-1:0] shadow_words [DEPTH];
	logic [IDX_W-1:0]  shadow_head;
	logic [CNT_W-1:0]  shadow_count;

	deq_result_t results_due [$];
	dir_row_t    dir_rows [$];
	int          errors = 0;
	bit          steady = 1'b0;
	int          rx_left = 0;

	double_ended_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected result of one request; updates the shadow queue
	function automatic deq_result_t predict_deque(input logic [REQ_W-1:0] kind,
			input logic [WORD_W-1:0] val);
		deq_result_t r;
		logic [IDX_W-1:0] pos;
		r.pop_value = MOST_NEG;
		r.status = STAT_DONE;
		if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) begin
			if (shadow_count == CNT_W'(DEPTH)) begin
				r.status = STAT_FULL;
			end else if (kind == REQ_PUSH_FRONT) begin
				shadow_head = shadow_head - 1'b1;
				shadow_words[shadow_head] = val;
				shadow_count = shadow_count + 1'b1;
			end else begin
				pos = IDX_W'(shadow_head + shadow_count);
				shadow_words[pos] = val;
				shadow_count = shadow_count + 1'b1;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = STAT_EMPTY;
			end else if (kind == REQ_POP_FRONT) begin
				r.pop_value = shadow_words[shadow_head];
				shadow_head = shadow_head + 1'b1;
				shadow_count = shadow_count - 1'b1;
			end else begin
				pos = IDX_W'(shadow_head + shadow_count - 1'b1);
				r.pop_value = shadow_words[pos];
				shadow_count = shadow_count - 1'b1;
			end
		end
		r.entry_count = shadow_count;
		r.is_empty = (shadow_count == 0);
		return r;
	endfunction

	// Idle length: mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 6);
		return $urandom_range(15, 40);
	endfunction

	function automatic int sender_gap();
		if (steady || $urandom_range(0, 99) < 55) return 0;
		return gap_len();
	endfunction

	// Push word with extra weight on the extremes
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return MOST_NEG;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_row(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] val,
			input int reps, input bit rnd, input bit typed, input logic [WORD_W-1:0] pop,
			input logic [STAT_W-1:0] st, input logic [CNT_W-1:0] cnt, input logic emp);
		dir_row_t row;
		row.kind = kind;
		row.value = val;
		row.reps = reps;
		row.rnd = rnd;
		row.typed = typed;
		row.want.pop_value = pop;
		row.want.status = st;
		row.want.entry_count = cnt;
		row.want.is_empty = emp;
		dir_rows.push_back(row);
	endtask

	// Present one request and wait for it to be taken; entered at a rising edge
	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] val,
			input int gap, input bit typed, input deq_result_t want);
		deq_result_t pred;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		pred = predict_deque(kind, val);
		results_due.push_back(typed ? want : pred);
	endtask

	// Hold the sender off until every outstanding result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	// Result monitor and receiver stalls
	always @(posedge clk) begin
		deq_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t unexpected result, expected none actual %h", $time,
						m_tdata);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (m_tdata[WORD_W-1:0] !== want.pop_value) begin
						$display("%0t pop_value expected %h actual %h", $time,
							want.pop_value, m_tdata[WORD_W-1:0]);
						errors++;
					end
					if (m_tdata[ST_LSB +: STAT_W] !== want.status) begin
						$display("%0t status expected %0d actual %0d", $time,
							want.status, m_tdata[ST_LSB +: STAT_W]);
						errors++;
					end
					if (m_tdata[CNT_LSB +: CNT_W] !== want.entry_count) begin
						$display("%0t entry_count expected %0d actual %0d", $time,
							want.entry_count, m_tdata[CNT_LSB +: CNT_W]);
						errors++;
					end
					if (m_tdata[EMP_BIT] !== want.is_empty) begin
						$display("%0t is_empty expected %0d actual %0d", $time,
							want.is_empty, m_tdata[EMP_BIT]);
						errors++;
					end
					if (m_tdata[M_TDATA_W-1:EMP_BIT+1] !== '0) begin
						$display("%0t zero fill expected 0 actual %h", $time,
							m_tdata[M_TDATA_W-1:EMP_BIT+1]);
						errors++;
					end
				end
			end
			if (rx_left == 0) begin
				if (steady) begin
					m_tready <= 1'b1;
					rx_left = 1;
				end else if ($urandom_range(0, 1) == 1) begin
					m_tready <= 1'b1;
					rx_left = $urandom_range(1, 8);
				end else begin
					m_tready <= 1'b0;
					rx_left = gap_len();
				end
			end
			rx_left--;
		end
	end

	// Stimulus
	initial begin
		deq_result_t none;
		int sent;
		int phase_len;
		int bias;
		int push_pct;
		logic [REQ_W-1:0] kind;
		none = '{default: '0};
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_PUSH_FRONT;
		arst_n = 1'b0;
		shadow_head = '0;
		shadow_count = '0;
		foreach (shadow_words[i]) shadow_words[i] = '0;

		// Empty pops, extremes, front and back wrap, full refusal, drain
		add_row(REQ_POP_FRONT, 32'h0, 1, 0, 1, MOST_NEG, STAT_EMPTY, 7'd0, 1'b1);
		add_row(REQ_POP_BACK, 32'hFFFF_FFFF, 1, 0, 1, MOST_NEG, STAT_EMPTY, 7'd0, 1'b1);
		add_row(REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1, 0, 1, MOST_NEG, STAT_DONE, 7'd1, 1'b0);
		add_row(REQ_PUSH_BACK, 32'h8000_0000, 1, 0, 1, MOST_NEG, STAT_DONE, 7'd2, 1'b0);
		add_row(REQ_PUSH_FRONT, 32'h0, 1, 0, 1, MOST_NEG, STAT_DONE, 7'd3, 1'b0);
		add_row(REQ_PUSH_BACK, 32'hFFFF_FFFF, 1, 0, 1, MOST_NEG, STAT_DONE, 7'd4, 1'b0);
		add_row(REQ_POP_FRONT, 32'h0, 1, 0, 0, '0, '0, '0, 1'b0);
		add_row(REQ_POP_BACK, 32'h0, 1, 0, 0, '0, '0, '0, 1'b0);
		add_row(REQ_POP_BACK, 32'h0, 1, 0, 0, '0, '0, '0, 1'b0);
		add_row(REQ_POP_FRONT, 32'h0, 1, 0, 0, '0, '0, '0, 1'b0);
		add_row(REQ_POP_BACK, 32'h1234_5678, 1, 0, 1, MOST_NEG, STAT_EMPTY, 7'd0, 1'b1);
		add_row(REQ_PUSH_BACK, 32'h5555_5555, 1, 0, 1, MOST_NEG, STAT_DONE, 7'd1, 1'b0);
		add_row(REQ_POP_FRONT, 32'h0, 1, 0, 0, '0, '0, '0, 1'b0);
		add_row(REQ_PUSH_FRONT, 32'hAAAA_AAAA, 1, 0, 1, MOST_NEG, STAT_DONE, 7'd1, 1'b0);
		add_row(REQ_POP_BACK, 32'h0, 1, 0, 0, '0, '0, '0, 1'b0);
		add_row(REQ_PUSH_BACK, 32'h0, DEPTH - 1, 1, 0, '0, '0, '0, 1'b0);
		add_row(REQ_PUSH_FRONT, 32'h1, 1, 0, 1, MOST_NEG, STAT_DONE, 7'd64, 1'b0);
		add_row(REQ_PUSH_FRONT, 32'h2, 1, 0, 1, MOST_NEG, STAT_FULL, 7'd64, 1'b0);
		add_row(REQ_PUSH_BACK, 32'hFFFF_FFFF, 1, 0, 1, MOST_NEG, STAT_FULL, 7'd64, 1'b0);
		add_row(REQ_POP_BACK, 32'h0, 1, 0, 0, '0, '0, '0, 1'b0);
		add_row(REQ_PUSH_BACK, 32'h3, 1, 0, 1, MOST_NEG, STAT_DONE, 7'd64, 1'b0);
		add_row(REQ_POP_FRONT, 32'h0, DEPTH, 0, 0, '0, '0, '0, 1'b0);
		add_row(REQ_POP_FRONT, 32'h0, 1, 0, 1, MOST_NEG, STAT_EMPTY, 7'd0, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].reps; k++) begin
				send_req(dir_rows[i].kind, dir_rows[i].rnd ? $urandom : dir_rows[i].value,
					sender_gap(), dir_rows[i].typed, dir_rows[i].want);
			end
		end
		wait_drained();

		// Random phases: fill-heavy, drain-heavy, balanced and churn
		sent = 0;
		while (sent < RANDOM_REQS) begin
			phase_len = $urandom_range(20, 80);
			bias = $urandom_range(0, 3);
			steady = ($urandom_range(0, 5) == 0);
			case (bias)
				0: push_pct = 80;
				1: push_pct = 20;
				2: push_pct = 50;
				default: push_pct = 55;
			endcase
			for (int k = 0; k < phase_len && sent < RANDOM_REQS; k++) begin
				if ($urandom_range(0, 99) < push_pct)
					kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
				else
					kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
				send_req(kind, pick_word(), sender_gap(), 1'b0, none);
				sent++;
				if (sent == RANDOM_REQS / 2) wait_drained();
			end
		end
		steady = 1'b0;

		// Drain and watch for stray results
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
		repeat (10) @(posedge clk);
		if (errors == 0 && results_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
